[design/vst_pkg.sv]
// Shared constants and types of the vector similarity top-k search.
package vst_pkg;

  localparam int unsigned ENTRIES_DEF  = 256;
  localparam int unsigned DIM_DEF      = 256;
  localparam int unsigned TOPK_MAX_DEF = 16;

  localparam int unsigned ELEM_W  = 16;
  localparam int unsigned SCORE_W = 31;
  localparam int unsigned TOPK_W  = 5;
  localparam logic [TOPK_W-1:0] TOPK_RST = 5'd10;

  typedef enum logic [1:0] {
    CMD_WRITE = 2'd0,
    CMD_CLEAR = 2'd1,
    CMD_QUERY = 2'd2,
    CMD_NONE  = 2'd3
  } cmd_e;

  typedef enum logic [7:0] {
    ST_IDLE    = 8'b0000_0001,
    ST_LEN_RD  = 8'b0000_0010,
    ST_LEN_CHK = 8'b0000_0100,
    ST_DOT     = 8'b0000_1000,
    ST_DRAIN   = 8'b0001_0000,
    ST_SCORE   = 8'b0010_0000,
    ST_INSERT  = 8'b0100_0000,
    ST_EMIT    = 8'b1000_0000
  } state_e;

endpackage

[design/vector_similarity_topk_top.sv]
// Top level of the vector similarity top-k search.
// Write, clear and query element items are accepted while idle (ready high).
// A last query element starts a table scan: each entry's length is read and
// checked, and each entry whose length matches runs a dot product on the single
// shared multiplier and the one-read vector memory port. Results then leave one
// per cycle while ready. Reset (async, active low) empties all entries, clears
// the ranking and sets top_k to 10; vector and query memories are not cleared.
module vector_similarity_topk_top #(
  parameter int unsigned ENTRIES  = vst_pkg::ENTRIES_DEF,
  parameter int unsigned DIM      = vst_pkg::DIM_DEF,
  parameter int unsigned TOPK_MAX = vst_pkg::TOPK_MAX_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [4:0]  cfg_wdata_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  cmd_i,
  input  logic [7:0]  entry_index_i,
  input  logic [7:0]  element_index_i,
  input  logic signed [15:0] element_value_i,
  input  logic        last_element_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [7:0]  result_index_o,
  output logic [30:0] score_o,
  output logic        result_valid_o,
  output logic        last_result_o
);

  localparam int unsigned EW    = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int unsigned DW    = (DIM > 1) ? $clog2(DIM) : 1;
  localparam int unsigned LW    = $clog2(DIM + 1);
  localparam int unsigned AW    = $clog2(ENTRIES * DIM);
  localparam int unsigned KW    = $clog2(TOPK_MAX + 1);
  localparam int unsigned IW    = (TOPK_MAX > 1) ? $clog2(TOPK_MAX) : 1;
  localparam int unsigned ACC_W = 32 + DW + 2;
  localparam int unsigned SW    = vst_pkg::SCORE_W;

  vst_pkg::state_e state_q, state_d;

  logic [4:0]    top_k_q;
  logic [KW-1:0] k_q;
  logic [LW-1:0] qlen_q;
  logic [EW-1:0] e_q;
  logic [DW-1:0] i_q;
  logic [AW-1:0] base_q;
  logic          p1_q, p2_q;
  logic signed [31:0]      prod_q;
  logic signed [ACC_W-1:0] acc_q;
  logic [SW-1:0] score_q;
  logic [KW-1:0] cnt_q, r_q;
  logic [ENTRIES-1:0] ent_valid_q;
  logic [EW-1:0] slot_idx_q [TOPK_MAX];
  logic [SW-1:0] slot_sc_q  [TOPK_MAX];

  // input decode
  logic accept, ent_ok, el_ok;
  logic is_wr, is_clr, is_qry;
  logic [EW-1:0] ent;
  logic [LW-1:0] new_len;

  assign accept  = in_valid_i && in_ready_o;
  assign ent_ok  = 32'(entry_index_i) < ENTRIES;
  assign el_ok   = 32'(element_index_i) < DIM;
  assign ent     = EW'(entry_index_i);
  assign new_len = LW'(32'(element_index_i) + 32'd1);
  assign is_wr   = accept && (cmd_i == vst_pkg::CMD_WRITE) && ent_ok && el_ok;
  assign is_clr  = accept && (cmd_i == vst_pkg::CMD_CLEAR) && ent_ok;
  assign is_qry  = accept && (cmd_i == vst_pkg::CMD_QUERY) && el_ok;

  assign in_ready_o = (state_q == vst_pkg::ST_IDLE);

  // memories
  logic [15:0]   vec_rd, qry_rd;
  logic [LW-1:0] len_rd;

  vst_ram #(.WIDTH(16), .DEPTH(ENTRIES * DIM)) u_vec_ram (
    .clk_i   (clk_i),
    .we_i    (is_wr),
    .waddr_i (AW'(32'(ent) * DIM + 32'(element_index_i))),
    .wdata_i (element_value_i),
    .raddr_i (base_q + AW'(i_q)),
    .rdata_o (vec_rd)
  );

  vst_ram #(.WIDTH(16), .DEPTH(DIM)) u_qry_ram (
    .clk_i   (clk_i),
    .we_i    (is_qry),
    .waddr_i (DW'(element_index_i)),
    .wdata_i (element_value_i),
    .raddr_i (i_q),
    .rdata_o (qry_rd)
  );

  vst_ram #(.WIDTH(LW), .DEPTH(ENTRIES)) u_len_ram (
    .clk_i   (clk_i),
    .we_i    (is_wr && last_element_i),
    .waddr_i (ent),
    .wdata_i (new_len),
    .raddr_i (e_q),
    .rdata_o (len_rd)
  );

  // score from accumulated dot: (1 + dot) / 2, saturated
  logic signed [ACC_W-1:0] t_sum;
  logic [SW-1:0]           score_d;
  assign t_sum = acc_q + (ACC_W'(1) <<< 30);
  always_comb begin
    if (t_sum < 0) begin
      score_d = '0;
    end else if (t_sum > (ACC_W'(1) <<< 31)) begin
      score_d = SW'(1) << 30;
    end else begin
      score_d = t_sum[SW:1];
    end
  end

  // ranked insertion: slots holding a score at least as high stay put
  logic [TOPK_MAX-1:0] ge;
  logic                do_ins;
  logic [EW-1:0] ins_idx [TOPK_MAX];
  logic [SW-1:0] ins_sc  [TOPK_MAX];
  always_comb begin
    logic          gp;
    logic [EW-1:0] pidx;
    logic [SW-1:0] psc;
    gp   = 1'b1;
    pidx = '0;
    psc  = '0;
    for (int j = 0; j < TOPK_MAX; j++) begin
      ge[j] = (KW'(j) < cnt_q) && (slot_sc_q[j] >= score_q);
      if (ge[j]) begin
        ins_idx[j] = slot_idx_q[j];
        ins_sc[j]  = slot_sc_q[j];
      end else if (gp) begin
        ins_idx[j] = e_q;
        ins_sc[j]  = score_q;
      end else begin
        ins_idx[j] = pidx;
        ins_sc[j]  = psc;
      end
      gp   = ge[j];
      pidx = slot_idx_q[j];
      psc  = slot_sc_q[j];
    end
    do_ins = (cnt_q < k_q) || !ge[IW'(k_q - KW'(1))];
  end

  logic last_ent, match, last_dot, emit_last;
  assign last_ent  = (e_q == EW'(ENTRIES - 1));
  assign match     = ent_valid_q[e_q] && (len_rd == qlen_q);
  assign last_dot  = (LW'(i_q) == qlen_q - LW'(1));
  assign emit_last = (cnt_q == '0) || (r_q == cnt_q - KW'(1));

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      vst_pkg::ST_IDLE:    if (is_qry && last_element_i) state_d = vst_pkg::ST_LEN_RD;
      vst_pkg::ST_LEN_RD:  state_d = vst_pkg::ST_LEN_CHK;
      vst_pkg::ST_LEN_CHK: begin
        if (match)         state_d = vst_pkg::ST_DOT;
        else if (last_ent) state_d = vst_pkg::ST_EMIT;
        else               state_d = vst_pkg::ST_LEN_RD;
      end
      vst_pkg::ST_DOT:     if (last_dot) state_d = vst_pkg::ST_DRAIN;
      vst_pkg::ST_DRAIN:   if (!p1_q && !p2_q) state_d = vst_pkg::ST_SCORE;
      vst_pkg::ST_SCORE:   state_d = vst_pkg::ST_INSERT;
      vst_pkg::ST_INSERT:  state_d = last_ent ? vst_pkg::ST_EMIT : vst_pkg::ST_LEN_RD;
      vst_pkg::ST_EMIT:    if (out_ready_i && emit_last) state_d = vst_pkg::ST_IDLE;
      default:             state_d = vst_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= vst_pkg::ST_IDLE;
      top_k_q     <= vst_pkg::TOPK_RST;
      k_q         <= '0;
      qlen_q      <= '0;
      e_q         <= '0;
      i_q         <= '0;
      base_q      <= '0;
      p1_q        <= 1'b0;
      p2_q        <= 1'b0;
      cnt_q       <= '0;
      r_q         <= '0;
      ent_valid_q <= '0;
    end else begin
      state_q <= state_d;
      p1_q    <= (state_q == vst_pkg::ST_DOT);
      p2_q    <= p1_q;
      if (cfg_we_i) top_k_q <= cfg_wdata_i;
      if (is_wr && last_element_i) ent_valid_q[ent] <= 1'b1;
      if (is_clr) ent_valid_q[ent] <= 1'b0;

      unique case (state_q)
        vst_pkg::ST_IDLE: begin
          if (is_qry && last_element_i) begin
            qlen_q <= new_len;
            e_q    <= '0;
            base_q <= '0;
            cnt_q  <= '0;
            // top_k of zero acts as one, above the slot count as the slot count
            if (top_k_q == '0) k_q <= KW'(1);
            else if (32'(top_k_q) > TOPK_MAX) k_q <= KW'(TOPK_MAX);
            else k_q <= KW'(top_k_q);
          end
        end
        vst_pkg::ST_LEN_CHK: begin
          i_q <= '0;
          if (!match && !last_ent) begin
            e_q    <= e_q + EW'(1);
            base_q <= base_q + AW'(DIM);
          end
          if (!match && last_ent) r_q <= '0;
        end
        vst_pkg::ST_DOT:     i_q <= i_q + DW'(1);
        vst_pkg::ST_INSERT: begin
          if (do_ins && (cnt_q < k_q)) cnt_q <= cnt_q + KW'(1);
          if (last_ent) begin
            r_q <= '0;
          end else begin
            e_q    <= e_q + EW'(1);
            base_q <= base_q + AW'(DIM);
          end
        end
        vst_pkg::ST_EMIT:    if (out_ready_i) r_q <= r_q + KW'(1);
        default: ;
      endcase
    end
  end

  // datapath: one multiply and one accumulate per element
  always_ff @(posedge clk_i) begin
    if (state_q == vst_pkg::ST_LEN_CHK) acc_q <= '0;
    if (p1_q) prod_q <= $signed(qry_rd) * $signed(vec_rd);
    if (p2_q) acc_q <= acc_q + ACC_W'(prod_q);
    if (state_q == vst_pkg::ST_SCORE) score_q <= score_d;
    if ((state_q == vst_pkg::ST_INSERT) && do_ins) begin
      for (int j = 0; j < TOPK_MAX; j++) begin
        slot_idx_q[j] <= ins_idx[j];
        slot_sc_q[j]  <= ins_sc[j];
      end
    end
  end

  // result item: empty ranking gives one invalid item marked last
  assign out_valid_o    = (state_q == vst_pkg::ST_EMIT);
  assign result_valid_o = (cnt_q != '0);
  assign last_result_o  = emit_last;
  assign result_index_o = result_valid_o ? 8'(slot_idx_q[IW'(r_q)]) : 8'd0;
  assign score_o        = result_valid_o ? slot_sc_q[IW'(r_q)] : '0;

endmodule

[design/vst_ram.sv]
// Generic single-write, single-read RAM with registered read data.
module vst_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

[design/vst_chk.sv]
// Port-level checker for the vector similarity top-k search, with its bind.
module vst_chk (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_ready_o,
  input logic        out_valid_o,
  input logic        out_ready_i,
  input logic [30:0] score_o,
  input logic        result_valid_o,
  input logic        last_result_o
);

  // no item taken while results are pending
  a_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(in_ready_o && out_valid_o)) else $error("input ready during result output");

  a_nomatch_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !result_valid_o) |-> last_result_o)
    else $error("invalid result not marked last");

  a_score_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (score_o <= 31'h4000_0000)) else $error("score above one");

  a_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_ready_i && last_result_o) |=> (!out_valid_o && in_ready_o))
    else $error("output continues after last result");

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i) |=> (out_valid_o && $stable(score_o)))
    else $error("stalled result dropped or changed");

endmodule

bind vector_similarity_topk_top vst_chk u_vst_chk (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .in_ready_o     (in_ready_o),
  .out_valid_o    (out_valid_o),
  .out_ready_i    (out_ready_i),
  .score_o        (score_o),
  .result_valid_o (result_valid_o),
  .last_result_o  (last_result_o)
);

[test/vst_checker.sv]
// Checker for the vector similarity search: predicts ranked results and compares them.
module vst_checker (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [4:0]         cfg_wdata_i,
  input  logic               in_valid_i,
  input  logic               in_ready_o,
  input  logic [1:0]         cmd_i,
  input  logic [7:0]         entry_index_i,
  input  logic [7:0]         element_index_i,
  input  logic signed [15:0] element_value_i,
  input  logic               last_element_i,
  input  logic               out_valid_o,
  input  logic               out_ready_i,
  input  logic [7:0]         result_index_o,
  input  logic [30:0]        score_o,
  input  logic               result_valid_o,
  input  logic               last_result_o,
  output int                 fail_count_o,
  output int                 pending_o,
  output int                 queries_o,
  output int                 results_o
);

  typedef struct packed {
    logic [7:0]  idx;
    logic [30:0] score;
    logic        valid;
    logic        last;
  } match_t;

  localparam int NENT = 256;
  localparam int NDIM = 256;
  localparam int KMAX = 16;

  shortint     vec_mem [NENT][NDIM];
  int          vec_len [NENT];
  shortint     qry_mem [NDIM];
  logic [4:0]  topk;
  match_t      expected_matches[$];

  function automatic logic [30:0] dot_score(int ent, int qlen);
    longint acc;
    longint t;
    acc = 0;
    for (int i = 0; i < qlen; i++) acc += longint'(qry_mem[i]) * longint'(vec_mem[ent][i]);
    t = (longint'(1) << 30) + acc;
    if (t < 0) return '0;
    if (t > (longint'(1) << 31)) return 31'(1 << 30);
    return 31'(t / 2);
  endfunction

  // Scan the table in index order; strict compare keeps the lower index first on ties.
  function automatic void rank_query(int qlen);
    int          k;
    int          cnt;
    int          pos;
    int          j;
    logic [7:0]  ridx [KMAX];
    logic [30:0] rsc  [KMAX];
    logic [30:0] s;
    match_t      m;
    k = (topk < 1) ? 1 : ((topk > KMAX) ? KMAX : int'(topk));
    cnt = 0;
    for (int e = 0; e < NENT; e++) begin
      if (vec_len[e] == 0 || vec_len[e] != qlen) continue;
      s = dot_score(e, qlen);
      pos = cnt;
      while (pos > 0 && rsc[pos-1] < s) pos--;
      if (pos >= k) continue;
      j = (cnt < k) ? cnt : k - 1;
      for (; j > pos; j--) begin
        ridx[j] = ridx[j-1];
        rsc[j]  = rsc[j-1];
      end
      ridx[pos] = 8'(e);
      rsc[pos]  = s;
      if (cnt < k) cnt++;
    end
    if (cnt == 0) begin
      m = '{idx: '0, score: '0, valid: 1'b0, last: 1'b1};
      expected_matches.insert(expected_matches.size(), m);
    end
    for (int r = 0; r < cnt; r++) begin
      m = '{idx: ridx[r], score: rsc[r], valid: 1'b1, last: (r == cnt - 1)};
      expected_matches.insert(expected_matches.size(), m);
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    match_t exp_m;
    match_t got;
    if (!rst_ni) begin
      for (int e = 0; e < NENT; e++) vec_len[e] = 0;
      topk = vst_pkg::TOPK_RST;
      expected_matches.delete();
      fail_count_o = 0;
      pending_o = 0;
      queries_o = 0;
      results_o = 0;
    end else begin
      if (cfg_we_i) topk = cfg_wdata_i;
      if (in_valid_i && in_ready_o) begin
        case (vst_pkg::cmd_e'(cmd_i))
          vst_pkg::CMD_WRITE: begin
            vec_mem[entry_index_i][element_index_i] = element_value_i;
            if (last_element_i) vec_len[entry_index_i] = int'(element_index_i) + 1;
          end
          vst_pkg::CMD_CLEAR: vec_len[entry_index_i] = 0;
          vst_pkg::CMD_QUERY: begin
            qry_mem[element_index_i] = element_value_i;
            if (last_element_i) begin
              queries_o++;
              rank_query(int'(element_index_i) + 1);
            end
          end
          default: ;
        endcase
      end
      if (out_valid_o && out_ready_i) begin
        results_o++;
        got = '{idx: result_index_o, score: score_o, valid: result_valid_o,
                last: last_result_o};
        if (expected_matches.size() == 0) begin
          fail_count_o++;
          $display("%0t: unexpected result idx=%0d score=%0d valid=%0b last=%0b",
                   $time, got.idx, got.score, got.valid, got.last);
        end else begin
          exp_m = expected_matches.pop_front();
          if (got !== exp_m) begin
            fail_count_o++;
            $display("%0t: mismatch expected idx=%0d score=%0d valid=%0b last=%0b",
                     $time, exp_m.idx, exp_m.score, exp_m.valid, exp_m.last);
            $display("%0t:          actual   idx=%0d score=%0d valid=%0b last=%0b",
                     $time, got.idx, got.score, got.valid, got.last);
          end
        end
      end
      pending_o = expected_matches.size();
    end
  end
endmodule

[test/tb_top.sv]
// Testbench top: stimulus, flow control and verdict for the vector similarity search.
module tb_top;

  logic               clk_i;
  logic               rst_ni;
  logic               cfg_we_i;
  logic [4:0]         cfg_wdata_i;
  logic               in_valid_i;
  logic               in_ready_o;
  logic [1:0]         cmd_i;
  logic [7:0]         entry_index_i;
  logic [7:0]         element_index_i;
  logic signed [15:0] element_value_i;
  logic               last_element_i;
  logic               out_valid_o;
  logic               out_ready_i;
  logic [7:0]         result_index_o;
  logic [30:0]        score_o;
  logic               result_valid_o;
  logic               last_result_o;

  int fail_count;
  int pending;
  int queries;
  int results;

  // flow-control knobs, percent out of 100
  int sender_idle_pct;
  int recv_stall_pct;
  int hold_cycles;   // nonzero asks the receiver for one long hold-off
  int items_sent;
  int idle_cnt;

  localparam int WATCHDOG_LIMIT = 20000;  // longer than the worst scan with no transfer
  localparam int SETTLE_CYCLES  = 20;

  vector_similarity_topk_top uut (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_wdata_i,
    .in_valid_i, .in_ready_o, .cmd_i, .entry_index_i, .element_index_i,
    .element_value_i, .last_element_i,
    .out_valid_o, .out_ready_i, .result_index_o, .score_o, .result_valid_o,
    .last_result_o
  );

  vst_checker chk (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_wdata_i,
    .in_valid_i, .in_ready_o, .cmd_i, .entry_index_i, .element_index_i,
    .element_value_i, .last_element_i,
    .out_valid_o, .out_ready_i, .result_index_o, .score_o, .result_valid_o,
    .last_result_o,
    .fail_count_o(fail_count), .pending_o(pending), .queries_o(queries),
    .results_o(results)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Receiver: random stalls per phase, plus one counted hold-off when asked.
  initial begin
    out_ready_i = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (hold_cycles > 0) begin
        out_ready_i <= 1'b0;
        hold_cycles--;
      end else begin
        out_ready_i <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  // Watchdog: cycles with no transfer on either channel.
  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) || !rst_ni) idle_cnt = 0;
    else idle_cnt++;
    if (idle_cnt >= WATCHDOG_LIMIT) begin
      $display("%0t: watchdog expired, %0d results still expected", $time, pending);
      $display("vector_similarity_topk_top test failed");
      $finish;
    end
  end

  // Returns at the edge where the item is accepted; valid is left high.
  task automatic send_item(vst_pkg::cmd_e c, int ent, int el, int val, bit last);
    bit rdy;
    if ($urandom_range(99) < sender_idle_pct) begin
      in_valid_i <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < sender_idle_pct);
    end
    in_valid_i      <= 1'b1;
    cmd_i           <= c;
    entry_index_i   <= 8'(ent);
    element_index_i <= 8'(el);
    element_value_i <= 16'(val);
    last_element_i  <= last;
    do begin
      @(negedge clk_i);
      rdy = in_ready_o;
      @(posedge clk_i);
    end while (!rdy);
    items_sent++;
  endtask

  // Whole vector or query: elements 0..len-1 in order, last on the final one.
  task automatic send_seq(vst_pkg::cmd_e c, int ent, int len, int vals[]);
    for (int i = 0; i < len; i++) send_item(c, ent, i, vals[i], i == len - 1);
  endtask

  // Drop valid, let every expected result arrive and the block settle.
  // The negedge lets the checker book the item accepted at this edge first.
  task automatic drain_all();
    in_valid_i <= 1'b0;
    @(negedge clk_i);
    wait (pending == 0);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_topk(int v);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= 5'(v);
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    @(posedge clk_i);
  endtask

  function automatic int rand_elem();
    case ($urandom_range(7))
      0: return -32768;
      1: return 32767;
      2: return 0;
      default: return int'($urandom_range(65535)) - 32768;
    endcase
  endfunction

  // One random burst: mostly whole vectors and queries of short lengths,
  // the rest clears, unused commands and unfinished sequences.
  task automatic random_burst();
    int vals[];
    int len;
    int kind;
    int ent;
    kind = $urandom_range(99);
    len  = ($urandom_range(9) == 0) ? $urandom_range(5, 8) : $urandom_range(1, 3);
    vals = new[len];
    foreach (vals[i]) vals[i] = rand_elem();
    ent = $urandom_range(255);
    if (kind < 45) send_seq(vst_pkg::CMD_WRITE, ent, len, vals);
    else if (kind < 75) send_seq(vst_pkg::CMD_QUERY, 0, len, vals);
    else if (kind < 82) send_item(vst_pkg::CMD_CLEAR, ent, $urandom_range(255), rand_elem(),
                                  $urandom_range(1));
    else if (kind < 88) send_item(vst_pkg::CMD_NONE, ent, $urandom_range(255), rand_elem(),
                                  $urandom_range(1));
    // unfinished vector or query: no last mark, so no length or search follows
    else if (kind < 94) send_item(vst_pkg::CMD_WRITE, ent, $urandom_range(255), rand_elem(),
                                  1'b0);
    else send_item(vst_pkg::CMD_QUERY, ent, $urandom_range(255), rand_elem(), 1'b0);
  endtask

  initial begin
    int topk_set[6] = '{1, 16, 0, 31, 7, 10};
    int sidle[6]    = '{0, 71, 0, 35, 71, 0};
    int rstall[6]   = '{0, 0, 71, 35, 71, 0};
    int v2[];
    rst_ni          = 1'b0;
    cfg_we_i        = 1'b0;
    cfg_wdata_i     = '0;
    in_valid_i      = 1'b0;
    cmd_i           = vst_pkg::CMD_WRITE;
    entry_index_i   = '0;
    element_index_i = '0;
    element_value_i = '0;
    last_element_i  = 1'b0;
    sender_idle_pct = 0;
    recv_stall_pct  = 0;
    hold_cycles     = 0;
    items_sent      = 0;
    idle_cnt        = 0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part at reset top_k.
    // Query before anything is stored: no match.
    v2 = '{-32768, -32768};
    send_seq(vst_pkg::CMD_QUERY, 0, 2, v2);
    // Saturating high score in entry 0, negative clamp in entry 255.
    send_seq(vst_pkg::CMD_WRITE, 0, 2, v2);
    v2 = '{32767, 32767};
    send_seq(vst_pkg::CMD_WRITE, 255, 2, v2);
    // Equal vectors in entries 2 and 1: tie, lower index ranks first.
    v2 = '{16384, -100};
    send_seq(vst_pkg::CMD_WRITE, 2, 2, v2);
    send_seq(vst_pkg::CMD_WRITE, 1, 2, v2);
    v2 = '{-32768, -32768};
    send_seq(vst_pkg::CMD_QUERY, 0, 2, v2);
    // Lone write and query items without last, and an unused command.
    send_item(vst_pkg::CMD_WRITE, 170, 255, 32767, 1'b0);
    send_item(vst_pkg::CMD_QUERY, 85, 128, -32768, 1'b0);
    send_item(vst_pkg::CMD_NONE, 255, 255, -1, 1'b1);
    // Clear entry 1, then query length 3 that nothing matches.
    send_item(vst_pkg::CMD_CLEAR, 1, 0, 0, 1'b0);
    v2 = '{0, 32767, -32768};
    send_seq(vst_pkg::CMD_QUERY, 0, 3, v2);
    v2 = '{32767, 12345};
    send_seq(vst_pkg::CMD_QUERY, 0, 2, v2);
    drain_all();

    // Random phases, each with its own top_k and flow-control mix.
    for (int ph = 0; ph < 6; ph++) begin
      write_topk(topk_set[ph]);
      sender_idle_pct = sidle[ph];
      recv_stall_pct  = rstall[ph];
      if (ph == 2) hold_cycles = 400;  // receiver backs up while queries keep coming
      for (int n = 0; n < 25; ) begin
        int start;
        start = items_sent;
        random_burst();
        n += items_sent - start;
      end
      drain_all();  // sender waits for every outstanding result
    end

    $display("Sent %0d items over 6 top_k settings and mixed stalls; %0d queries, %0d results.",
             items_sent, queries, results);
    if (fail_count == 0) $display("vector_similarity_topk_top test passed");
    else $display("vector_similarity_topk_top test failed");
    $finish;
  end
endmodule

[vector_similarity_topk_top.f]
design/vst_pkg.sv
design/vst_ram.sv
design/vector_similarity_topk_top.sv
design/vst_chk.sv
test/vst_checker.sv
test/tb_top.sv
